// ===== rtl/dnd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

  // Default sizes of the packet store and of the longest dotted name.
  localparam int unsigned PacketBytesDef  = 512;
  localparam int unsigned MaxNameCharsDef = 255;

  // A read position holds any 14-bit pointer target and one step past the store.
  localparam int unsigned PosW   = 15;
  localparam int unsigned LenW   = 8;
  localparam int unsigned JumpW  = 6;
  localparam int unsigned ConsW  = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;

  localparam logic [ByteW-1:0] PtrMark  = 8'd192;
  localparam logic [ByteW-1:0] DotChar  = 8'h2E;
  localparam logic [JumpW-1:0] MaxJumpsReset = 6'd16;

  // Result status codes.
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusJumps = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  // Requests from the sequencer to the name packer.
  typedef struct packed {
    logic             clear;
    logic             put;
    logic             flush;
    logic [ByteW-1:0] ch;
  } pk_req_t;

endpackage

`default_nettype wire

// ===== rtl/dnd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/dnd_name_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnd_name_pack
  import dnd_pkg::*;
#(
  parameter int unsigned MAX_NAME_CHARS = MaxNameCharsDef,
  localparam int unsigned NameWords = (MAX_NAME_CHARS + 3) / 4,
  localparam int unsigned NwAw = $clog2(NameWords)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pk_req_t         req_i,
  output logic [LenW-1:0]      name_len_o,
  output logic                 full_o,
  output logic                 we_o,
  output logic [NwAw-1:0]      waddr_o,
  output logic [WordW-1:0]     wdata_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_NAME_CHARS);

  logic [LenW-1:0]  len_q, len_d;
  logic [WordW-1:0] word_q, word_d;
  logic [LenW-1:0]  word_idx;
  logic [1:0]       lane;

  assign lane     = len_q[1:0];
  assign word_idx = len_q >> 2;

  // Characters gather into a 32-bit word; a full word goes to the name memory.
  always_comb begin
    len_d   = len_q;
    word_d  = word_q;
    we_o    = 1'b0;
    wdata_o = word_q;
    if (req_i.clear) begin
      len_d = '0;
    end else if (req_i.put) begin
      len_d = len_q + LenW'(1);
      unique case (lane)
        2'd0: word_d = {24'd0, req_i.ch};
        2'd1: word_d = {16'd0, req_i.ch, word_q[7:0]};
        2'd2: word_d = {8'd0, req_i.ch, word_q[15:0]};
        2'd3: word_d = {req_i.ch, word_q[23:0]};
        default: word_d = word_q;
      endcase
      we_o    = (lane == 2'd3);
      wdata_o = {req_i.ch, word_q[23:0]};
    end else if (req_i.flush) begin
      // A partly filled word is written at the end of the walk.
      we_o = (lane != 2'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign name_len_o = len_q;
  assign full_o     = (len_q >= MaxLen);
  assign waddr_o    = word_idx[NwAw-1:0];

endmodule

`default_nettype wire

// ===== rtl/dnd_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnd_walker
  import dnd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES   = PacketBytesDef,
  parameter int unsigned MAX_NAME_CHARS = MaxNameCharsDef,
  localparam int unsigned StAw = $clog2(PACKET_BYTES),
  localparam int unsigned NameWords = (MAX_NAME_CHARS + 3) / 4,
  localparam int unsigned NwAw = $clog2(NameWords)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              mode_i,
  input  wire logic [8:0]        start_pos_i,
  input  wire logic [JumpW-1:0]  max_jumps_i,
  output logic [StAw-1:0]        st_raddr_o,
  input  wire logic [ByteW-1:0]  st_rdata_i,
  output pk_req_t                pk_req_o,
  input  wire logic [LenW-1:0]   name_len_i,
  input  wire logic              name_full_i,
  output logic [NwAw-1:0]        nm_raddr_o,
  input  wire logic [WordW-1:0]  nm_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       name_chars_o,
  output logic [2:0]             char_count_o,
  output logic                   last_o,
  output logic [ConsW-1:0]       consumed_o,
  output logic [1:0]             status_o
);

  localparam logic [PosW-1:0] StoreEnd = PosW'(PACKET_BYTES);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_FETCH     = 9'b000000010,
    S_LEN       = 9'b000000100,
    S_PTR       = 9'b000001000,
    S_CHR       = 9'b000010000,
    S_FLUSH     = 9'b000100000,
    S_EMIT_REQ  = 9'b001000000,
    S_EMIT_LOAD = 9'b010000000,
    S_EMIT_WAIT = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   pos_inc;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [5:0]        hi_q, hi_d;
  logic [JumpW-1:0]  jumps_q, jumps_d;
  logic [ConsW-1:0]  cons_q, cons_d;
  logic              jumped_q, jumped_d;
  logic [NwAw-1:0]   k_q, k_d;
  logic [LenW-1:0]   erem_q, erem_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [WordW-1:0]  chars_d;
  logic [2:0]        count_d;
  logic              last_d;
  logic [ConsW-1:0]  consumed_d;
  logic [1:0]        status_d;
  logic              pos_out;

  // The one position incrementer serves every step; pos_out bounds pos_q.
  assign pos_inc = pos_q + PosW'(1);
  assign pos_out = (pos_q >= StoreEnd);

  assign st_raddr_o = (state_q == S_LEN) ? pos_inc[StAw-1:0] : pos_q[StAw-1:0];
  assign nm_raddr_o = k_q;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: walk the encoded name one store byte at a time, then emit words.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    hi_d        = hi_q;
    jumps_d     = jumps_q;
    cons_d      = cons_q;
    jumped_d    = jumped_q;
    k_d         = k_q;
    erem_d      = erem_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    chars_d     = '0;
    count_d     = '0;
    last_d      = 1'b1;
    consumed_d  = '0;
    status_d    = StatusOk;
    pk_req_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && mode_i) begin
          pos_d          = PosW'(start_pos_i);
          rem_d          = '0;
          jumps_d        = '0;
          cons_d         = '0;
          jumped_d       = 1'b0;
          pk_req_o.clear = 1'b1;
          state_d        = S_FETCH;
        end
      end

      S_FETCH: begin
        if (pos_out) begin
          status_d = StatusRange;
          out_load = 1'b1;
        end else if (rem_q == '0) begin
          state_d = S_LEN;
        end else begin
          state_d = S_CHR;
        end
      end

      S_LEN: begin
        if (st_rdata_i == '0) begin
          if (!jumped_q) begin
            cons_d = cons_q + ConsW'(1);
          end
          state_d = S_FLUSH;
        end else if (st_rdata_i >= PtrMark) begin
          if (pos_inc >= StoreEnd) begin
            status_d = StatusRange;
            out_load = 1'b1;
          end else begin
            hi_d    = st_rdata_i[5:0];
            state_d = S_PTR;
          end
        end else if (name_len_i != '0 && name_full_i) begin
          status_d = StatusRange;
          out_load = 1'b1;
        end else begin
          if (!jumped_q) begin
            cons_d = cons_q + ConsW'(1);
          end
          pk_req_o.put = (name_len_i != '0);
          pk_req_o.ch  = DotChar;
          pos_d        = pos_inc;
          rem_d        = st_rdata_i;
          state_d      = S_FETCH;
        end
      end

      S_PTR: begin
        if (jumps_q >= max_jumps_i) begin
          status_d = StatusJumps;
          out_load = 1'b1;
        end else begin
          jumps_d = jumps_q + JumpW'(1);
          if (!jumped_q) begin
            cons_d = cons_q + ConsW'(2);
          end
          jumped_d = 1'b1;
          pos_d    = PosW'({hi_q, st_rdata_i});
          state_d  = S_FETCH;
        end
      end

      S_CHR: begin
        if (name_full_i) begin
          status_d = StatusRange;
          out_load = 1'b1;
        end else begin
          pk_req_o.put = 1'b1;
          pk_req_o.ch  = st_rdata_i;
          if (!jumped_q) begin
            cons_d = cons_q + ConsW'(1);
          end
          pos_d   = pos_inc;
          rem_d   = rem_q - LenW'(1);
          state_d = S_FETCH;
        end
      end

      S_FLUSH: begin
        pk_req_o.flush = 1'b1;
        erem_d         = name_len_i;
        k_d            = '0;
        state_d        = S_EMIT_REQ;
      end

      S_EMIT_REQ: begin
        state_d = S_EMIT_LOAD;
      end

      S_EMIT_LOAD: begin
        out_load   = 1'b1;
        chars_d    = (erem_q == '0) ? '0 : nm_rdata_i;
        count_d    = (erem_q >= LenW'(4)) ? 3'd4 : erem_q[2:0];
        last_d     = (erem_q <= LenW'(4));
        consumed_d = last_d ? cons_q : '0;
      end

      S_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_o) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + NwAw'(1);
            erem_d  = erem_q - LenW'(4);
            state_d = S_EMIT_REQ;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Every path that produces a result parks in the output wait state.
    if (out_load) begin
      out_valid_d = 1'b1;
      state_d     = S_EMIT_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      rem_q       <= '0;
      jumps_q     <= '0;
      cons_q      <= '0;
      jumped_q    <= 1'b0;
      k_q         <= '0;
      erem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      jumps_q     <= jumps_d;
      cons_q      <= cons_d;
      jumped_q    <= jumped_d;
      k_q         <= k_d;
      erem_q      <= erem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register and pointer high bits carry data only.
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    if (out_load) begin
      name_chars_o <= chars_d;
      char_count_o <= count_d;
      last_o       <= last_d;
      consumed_o   <= consumed_d;
      status_o     <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/dns_name_decompressor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// DNS name decompressor. Packet bytes are loaded into a packet store with
// mode 0 transactions, one per cycle, and produce no result. A mode 1
// transaction walks the encoded name at start_pos, following labels and
// 14-bit compression pointers, and returns the dotted name four characters
// per result, the last result carrying the bytes consumed at start_pos and
// the status. Errors (too many jumps, name too long, read outside the store)
// give a single result with the error status. A decode is handled by one
// sequencer around the single store read port: fetch and length or character
// steps per length or label byte, a pointer step per pointer, a flush step
// closing the name, then request, load and wait steps per result. No new
// transaction is taken until the last result of a decode is delivered.
module dns_name_decompressor
  import dnd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES   = PacketBytesDef,
  parameter int unsigned MAX_NAME_CHARS = MaxNameCharsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              mode_i,
  input  wire logic [8:0]        write_addr_i,
  input  wire logic [ByteW-1:0]  write_byte_i,
  input  wire logic [8:0]        start_pos_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [WordW-1:0]       name_chars_o,
  output logic [2:0]             char_count_o,
  output logic                   last_o,
  output logic [ConsW-1:0]       consumed_o,
  output logic [1:0]             status_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [JumpW-1:0]  cfg_max_jumps_i
);

  localparam int unsigned StAw = $clog2(PACKET_BYTES);
  localparam int unsigned NameWords = (MAX_NAME_CHARS + 3) / 4;
  localparam int unsigned NwAw = $clog2(NameWords);
  localparam logic [PosW-1:0] StoreEnd = PosW'(PACKET_BYTES);

  logic [JumpW-1:0] max_jumps_q;
  logic [PosW-1:0]  wa_ext;
  logic             st_we;
  logic [StAw-1:0]  st_raddr;
  logic [ByteW-1:0] st_rdata;
  pk_req_t          pk_req;
  logic [LenW-1:0]  name_len;
  logic             name_full;
  logic             nm_we;
  logic [NwAw-1:0]  nm_waddr;
  logic [WordW-1:0] nm_wdata;
  logic [NwAw-1:0]  nm_raddr;
  logic [WordW-1:0] nm_rdata;

  // Jump limit register; writes are taken at any time.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jumps_q <= MaxJumpsReset;
    end else if (cfg_valid_i) begin
      max_jumps_q <= cfg_max_jumps_i;
    end
  end

  // Byte loads land in the store; addresses past its end are dropped.
  assign wa_ext = PosW'(write_addr_i);
  assign st_we  = in_valid_i && in_ready_o && !mode_i && (wa_ext < StoreEnd);

  dnd_ram #(
    .WIDTH (ByteW),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (wa_ext[StAw-1:0]),
    .wdata_i (write_byte_i),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  dnd_name_pack #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (pk_req),
    .name_len_o (name_len),
    .full_o     (name_full),
    .we_o       (nm_we),
    .waddr_o    (nm_waddr),
    .wdata_o    (nm_wdata)
  );

  dnd_ram #(
    .WIDTH (WordW),
    .DEPTH (NameWords)
  ) u_name (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (nm_waddr),
    .wdata_i (nm_wdata),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  dnd_walker #(
    .PACKET_BYTES   (PACKET_BYTES),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .start_pos_i  (start_pos_i),
    .max_jumps_i  (max_jumps_q),
    .st_raddr_o   (st_raddr),
    .st_rdata_i   (st_rdata),
    .pk_req_o     (pk_req),
    .name_len_i   (name_len),
    .name_full_i  (name_full),
    .nm_raddr_o   (nm_raddr),
    .nm_rdata_i   (nm_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .name_chars_o (name_chars_o),
    .char_count_o (char_count_o),
    .last_o       (last_o),
    .consumed_o   (consumed_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

// ===== bench/dns_name_decompressor_tb.sv =====
`timescale 1ns / 1ps

module dns_name_decompressor_tb;
  import dnd_pkg::*;

  // Operation codes carried on the mode input.
  localparam bit ModeWrite  = 1'b0;
  localparam bit ModeDecode = 1'b1;

  localparam int unsigned IdlePercent  = 38;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned RandomItems  = 160;
  localparam int unsigned PhaseCount   = 4;
  localparam int unsigned LaidOutEnd   = 235;
  localparam int unsigned TailStart    = 509;

  // One result word of a decoded name.
  typedef struct packed {
    logic [WordW-1:0] chars;
    logic [2:0]       count;
    logic             last_word;
    logic [ConsW-1:0] consumed;
    logic [1:0]       status;
  } name_word_t;

  // Shadow of the packet store and jump limit, plus the queue of expected name words.
  class name_scoreboard;
    bit [ByteW-1:0] packet_image[PacketBytesDef];
    bit             written[PacketBytesDef];
    bit             read_blank;
    bit [JumpW-1:0] jump_limit;
    bit [ByteW-1:0] dotted[MaxNameCharsDef];
    int unsigned    dotted_len;
    name_word_t     expected_words[$];
    int unsigned    decodes;
    int unsigned    words_seen;
    int unsigned    mismatches;
    int unsigned    status_seen[3];

    function new();
      jump_limit = MaxJumpsReset;
    endfunction

    function void set_jump_limit(bit [JumpW-1:0] value);
      jump_limit = value;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // Reads one shadow entry and notes when that entry was never written.
    function bit [ByteW-1:0] peek(int unsigned a);
      if (!written[a]) read_blank = 1'b1;
      return packet_image[a];
    endfunction

    // Appends one character unless the name would grow past its limit.
    function bit append_char(bit [ByteW-1:0] c);
      if (dotted_len >= MaxNameCharsDef) return 1'b0;
      dotted[dotted_len] = c;
      dotted_len++;
      return 1'b1;
    endfunction

    // Walks the encoded name at start and returns its status and bytes used.
    function bit [1:0] walk_name(int unsigned start, output int unsigned used);
      int unsigned pos;
      int unsigned jumps;
      int unsigned remaining;
      bit [ByteW-1:0] b;
      bit jumped;
      pos = start;
      jumps = 0;
      used = 0;
      jumped = 1'b0;
      dotted_len = 0;
      read_blank = 1'b0;
      forever begin
        if (pos >= PacketBytesDef) return StatusRange;
        b = peek(pos);
        if (b == 0) begin
          if (!jumped) used++;
          return StatusOk;
        end
        // Compression pointer: the low six bits and the next byte give the target.
        if (b >= PtrMark) begin
          if (pos + 1 >= PacketBytesDef) return StatusRange;
          jumps++;
          if (jumps > jump_limit) return StatusJumps;
          if (!jumped) begin
            used += 2;
            jumped = 1'b1;
          end
          pos = 32'({b[5:0], peek(pos + 1)});
          continue;
        end
        // Plain label, including the reserved length values.
        if (!jumped) used++;
        if (dotted_len > 0 && !append_char(DotChar)) return StatusRange;
        pos++;
        remaining = 32'(b);
        while (remaining > 0) begin
          if (pos >= PacketBytesDef) return StatusRange;
          if (!append_char(peek(pos))) return StatusRange;
          if (!jumped) used++;
          pos++;
          remaining--;
        end
      end
    endfunction

    // True when a decode at start reads only entries that were written.
    function bit safe_start(int unsigned start);
      int unsigned used;
      void'(walk_name(start, used));
      return !read_blank;
    endfunction

    // Applies an accepted input transaction and queues the words it should produce.
    function void note_item(bit mode, bit [8:0] addr, bit [ByteW-1:0] data, bit [8:0] start);
      bit [1:0] st;
      int unsigned used;
      int unsigned nwords;
      int unsigned k;
      int unsigned j;
      name_word_t w;
      if (mode == ModeWrite) begin
        packet_image[addr] = data;
        written[addr] = 1'b1;
        return;
      end
      decodes++;
      st = walk_name(start, used);
      status_seen[st]++;
      if (st != StatusOk) begin
        w = '0;
        w.last_word = 1'b1;
        w.status = st;
        expected_words.push_back(w);
        return;
      end
      nwords = (dotted_len + 3) / 4;
      if (nwords == 0) nwords = 1;
      for (k = 0; k < nwords; k++) begin
        w = '0;
        for (j = 0; j < 4; j++) begin
          if (k * 4 + j < dotted_len) begin
            w.chars[8 * j +: 8] = dotted[k * 4 + j];
            w.count++;
          end
        end
        w.last_word = (k + 1 == nwords);
        if (w.last_word) w.consumed = used[ConsW-1:0];
        expected_words.push_back(w);
      end
    endfunction

    // Compares one delivered word with the oldest expectation.
    function void check_word(logic [WordW-1:0] chars, logic [2:0] count, logic last_word,
                             logic [ConsW-1:0] consumed, logic [1:0] status);
      name_word_t want;
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("Result transaction with nothing expected: name_chars %h, status %0d",
               chars, status);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (chars !== want.chars) begin
        $error("name_chars: expected %h, got %h", want.chars, chars);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("char_count: expected %0d, got %0d", want.count, count);
        mismatches++;
      end
      if (last_word !== want.last_word) begin
        $error("last: expected %0d, got %0d", want.last_word, last_word);
        mismatches++;
      end
      if (consumed !== want.consumed) begin
        $error("consumed: expected %0d, got %0d", want.consumed, consumed);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             mode_i;
  logic [8:0]       write_addr_i;
  logic [ByteW-1:0] write_byte_i;
  logic [8:0]       start_pos_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [WordW-1:0] name_chars_o;
  logic [2:0]       char_count_o;
  logic             last_o;
  logic [ConsW-1:0] consumed_o;
  logic [1:0]       status_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [JumpW-1:0] cfg_max_jumps_i;

  name_scoreboard   board;
  bit               steady;
  int unsigned      items_sent;
  int unsigned      quiet_cycles;
  bit [ByteW-1:0]   layout[PacketBytesDef];
  int unsigned      recent_starts[$];

  dns_name_decompressor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .write_addr_i    (write_addr_i),
    .write_byte_i    (write_byte_i),
    .start_pos_i     (start_pos_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .name_chars_o    (name_chars_o),
    .char_count_o    (char_count_o),
    .last_o          (last_o),
    .consumed_o      (consumed_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_max_jumps_i (cfg_max_jumps_i)
  );

  always #10 clk_i = ~clk_i;

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Every delivered result transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_word(name_chars_o, char_count_o, last_o, consumed_o, status_o);
    end
  end

  // Ends the run if no channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results still expected",
               quiet_cycles, board.pending());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one input transaction, keeping valid high from a previous one if no idle falls.
  task automatic send_item(bit mode, bit [8:0] addr, bit [ByteW-1:0] data, bit [8:0] start);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    write_addr_i <= addr;
    write_byte_i <= data;
    start_pos_i  <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(mode, addr, data, start);
    items_sent++;
  endtask

  task automatic store_byte(int unsigned addr, bit [ByteW-1:0] data);
    send_item(ModeWrite, addr[8:0], data, 9'($urandom_range(0, 511)));
  endtask

  // A decode goes out only when its walk touches written entries alone.
  task automatic decode(int unsigned start);
    if (board.safe_start(start)) begin
      send_item(ModeDecode, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                start[8:0]);
    end
  endtask

  // Holds the sender off until every expected result has arrived, then lets the block settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_jumps(bit [JumpW-1:0] value);
    cfg_valid_i     <= 1'b1;
    cfg_max_jumps_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_jump_limit(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void put_label(int unsigned at, string txt);
    layout[at] = 8'(txt.len());
    for (int i = 0; i < txt.len(); i++) layout[at + 1 + i] = txt[i];
  endfunction

  function automatic void put_run(int unsigned at, int unsigned len, bit [ByteW-1:0] first);
    layout[at] = 8'(len);
    for (int i = 0; i < len; i++) layout[at + 1 + i] = 8'(first + i % 26);
  endfunction

  // Writes a name with random labels of up to 70 bytes, ended by a zero or a pointer to an
  // earlier name, and decodes it at its start and sometimes at a later label.
  task automatic random_name();
    bit [ByteW-1:0] encoded[$];
    int unsigned    label_starts[$];
    int unsigned    nlabels;
    int unsigned    len;
    int unsigned    base;
    int unsigned    target;
    bit [ByteW-1:0] hi;
    nlabels = $urandom_range(0, 4);
    repeat (nlabels) begin
      label_starts.push_back(encoded.size());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
      encoded.push_back(8'(len));
      repeat (len) encoded.push_back(8'($urandom_range(0, 255)));
    end
    if (recent_starts.size() != 0 && $urandom_range(0, 1) == 1) begin
      target = recent_starts[$urandom_range(0, recent_starts.size() - 1)];
      hi = PtrMark | {2'b00, target[13:8]};
      encoded.push_back(hi);
      encoded.push_back(target[7:0]);
    end else begin
      encoded.push_back(8'd0);
    end
    base = $urandom_range(0, PacketBytesDef - encoded.size());
    foreach (encoded[i]) store_byte(base + i, encoded[i]);
    decode(base);
    if (label_starts.size() != 0 && $urandom_range(0, 1) == 1) begin
      decode(base + label_starts[$urandom_range(0, label_starts.size() - 1)]);
    end
    recent_starts.push_back(base);
    if (recent_starts.size() > 8) void'(recent_starts.pop_front());
  endtask

  // One random step: mostly proper names, the rest noise and broken encodings.
  task automatic random_item();
    int unsigned    pick;
    int unsigned    pos;
    bit [ByteW-1:0] hi;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      random_name();
    end else if (pick < 80) begin
      decode($urandom_range(0, 511));
    end else if (pick < 88) begin
      pos = $urandom_range(0, 510);
      hi = PtrMark | 8'($urandom_range(0, 63));
      store_byte(pos, hi);
      store_byte(pos + 1, 8'($urandom_range(0, 255)));
      decode(pos);
    end else if (pick < 95) begin
      pos = $urandom_range(400, 511);
      store_byte(pos, 8'($urandom_range(1, 191)));
      decode(pos);
    end else begin
      store_byte($urandom_range(0, 511), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    bit [JumpW-1:0] limit;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    mode_i          = ModeWrite;
    write_addr_i    = '0;
    write_byte_i    = '0;
    start_pos_i     = '0;
    out_ready_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_max_jumps_i = MaxJumpsReset;
    steady          = 1'b0;
    items_sent      = 0;
    quiet_cycles    = 0;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Store image: plain names, pointers, a pointer loop, an out-of-range pointer,
    // a self-referencing label that grows too long, a reserved-length label,
    // a name of exactly the longest length, and labels at the end of the store.
    foreach (layout[i]) layout[i] = 8'd0;
    put_label(1, "www");
    put_label(5, "example");
    put_label(13, "com");
    layout[18] = PtrMark;
    layout[19] = 8'd5;
    put_label(20, "ab");
    layout[23] = PtrMark;
    layout[24] = 8'd1;
    layout[25] = PtrMark;
    layout[26] = 8'd25;
    layout[27] = 8'hFF;
    layout[28] = 8'hFF;
    layout[29] = PtrMark;
    layout[30] = 8'd20;
    put_run(32, 63, "a");
    layout[96] = PtrMark;
    layout[97] = 8'd32;
    put_run(98, 64, "A");
    // Four overlapping 63-character labels chained by pointers give exactly the
    // longest name in a small footprint.
    put_run(164, 63, "a");
    layout[166] = 8'd63;
    layout[168] = 8'd63;
    layout[170] = 8'd63;
    layout[228] = PtrMark;
    layout[229] = 8'd166;
    layout[230] = PtrMark;
    layout[231] = 8'd168;
    layout[232] = PtrMark;
    layout[233] = 8'd170;
    layout[234] = 8'd0;
    put_label(509, "x");
    layout[509] = 8'd5;
    layout[511] = PtrMark;

    // Only the laid-out regions are loaded; random decodes skip anything unwritten.
    for (int a = 0; a < LaidOutEnd; a++) store_byte(a, layout[a]);
    for (int a = TailStart; a < PacketBytesDef; a++) store_byte(a, layout[a]);

    // Directed decodes with the jump limit at its reset value.
    decode(0);
    decode(1);
    decode(5);
    decode(13);
    decode(18);
    decode(20);
    decode(25);
    decode(27);
    decode(29);
    decode(32);
    decode(98);
    decode(164);
    decode(509);
    decode(511);
    store_byte(511, 8'd0);
    decode(511);
    store_byte(511, PtrMark);

    // A jump limit of one allows one pointer only.
    drain_results();
    write_max_jumps(6'd1);
    decode(18);
    decode(29);
    decode(32);
    decode(164);

    // The highest jump limit still stops the loop and the overlong name.
    drain_results();
    write_max_jumps(6'd63);
    decode(25);
    decode(32);
    decode(29);

    // Random phases, each under its own jump limit; the third runs without idling.
    phase_end = items_sent;
    for (phase = 0; phase < PhaseCount; phase++) begin
      drain_results();
      case (phase)
        0: limit = 6'($urandom_range(1, 63));
        1: limit = 6'd2;
        2: limit = 6'd63;
        default: limit = 6'($urandom_range(1, 63));
      endcase
      write_max_jumps(limit);
      steady = (phase == 2);
      phase_end = items_sent + RandomItems / PhaseCount;
      while (items_sent < phase_end) random_item();
    end
    steady = 1'b0;
    drain_results();

    $display("Run covered %0d input transactions and %0d decodes giving %0d result words.",
             items_sent, board.decodes, board.words_seen);
    $display("Decode outcomes: %0d names, %0d jump-limit errors, %0d length or range errors.",
             board.status_seen[StatusOk], board.status_seen[StatusJumps],
             board.status_seen[StatusRange]);
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dnd_pkg.sv
rtl/dnd_ram.sv
rtl/dnd_name_pack.sv
rtl/dnd_walker.sv
rtl/dns_name_decompressor.sv
bench/dns_name_decompressor_tb.sv
